// File: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another one in the same cycle.
`define CHK_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another one in the following cycle.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/uctc_pkg.sv
package uctc_pkg;

  // Widths of the internal day count and second-of-day.
  localparam int DAYS_W = 16;
  localparam int SOD_W  = 17;

  // Register stages in the date and clock splitters (kept equal for alignment).
  localparam int SPLIT_STAGES = 6;
  // Register stages of the whole pipeline.
  localparam int PIPE_STAGES  = SPLIT_STAGES + 3;

  localparam logic [31:0] SECS_PER_HOUR = 32'(1 * 3600);
  localparam logic [31:0] SECS_PER_DAY  = 32'(24 * 3600);
  localparam logic [4:0]  HOURS_PER_DAY = 5'd24;

  // Calendar constants of the era-based day/date conversion.
  localparam logic [19:0] EPOCH_SHIFT  = 20'd719468;
  localparam logic [19:0] ERA4_START   = 20'd584388;
  localparam logic [19:0] ERA5_START   = 20'd730485;
  localparam logic [11:0] ERA4_YEAR    = 12'd1600;
  localparam logic [11:0] ERA5_YEAR    = 12'd2000;
  localparam logic [11:0] NONLEAP_CENT = 12'd2100;

  localparam logic [3:0] MONTH_MAR = 4'd3;
  localparam logic [3:0] MONTH_OCT = 4'd10;
  localparam logic [2:0] SUNDAY    = 3'd0;
  // Earliest day of month that a last Sunday of a 31-day month can fall on.
  localparam logic [5:0] LAST_WEEK_START = 6'd25;

  // Reciprocal multipliers: floor(x / D) == (x * ceil(2^K / D)) >> K,
  // exact for x below 2^(K - ceil(log2 D)).
  localparam int DAY_K = 35;   // utc >> 7 divided by 675
  localparam logic [25:0] DAY_MUL = 26'(((64'd1 << DAY_K) + 64'd674) / 64'd675);
  localparam int WD_K = 19;    // divide by 7
  localparam logic [16:0] WD_MUL = 17'(((64'd1 << WD_K) + 64'd6) / 64'd7);
  localparam int C4Y_K = 29;   // divide by 1460
  localparam logic [18:0] C4Y_MUL = 19'(((64'd1 << C4Y_K) + 64'd1459) / 64'd1460);
  localparam int YR_K = 27;    // divide by 365
  localparam logic [18:0] YR_MUL = 19'(((64'd1 << YR_K) + 64'd364) / 64'd365);
  localparam int MP_K = 19;    // divide by 153
  localparam logic [11:0] MP_MUL = 12'(((64'd1 << MP_K) + 64'd152) / 64'd153);
  localparam int HR_K = 29;    // divide by 3600
  localparam logic [17:0] HR_MUL = 18'(((64'd1 << HR_K) + 64'd3599) / 64'd3600);
  localparam int MN_K = 18;    // divide by 60
  localparam logic [12:0] MN_MUL = 13'(((64'd1 << MN_K) + 64'd59) / 64'd60);

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday;
    logic [8:0]  yday;
  } civil_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } hms_t;

  // First day (March-based day of year) of each March-based month.
  function automatic logic [8:0] mp_start(input logic [3:0] mp);
    case (mp)
      4'd0:    mp_start = 9'd0;
      4'd1:    mp_start = 9'd31;
      4'd2:    mp_start = 9'd61;
      4'd3:    mp_start = 9'd92;
      4'd4:    mp_start = 9'd122;
      4'd5:    mp_start = 9'd153;
      4'd6:    mp_start = 9'd184;
      4'd7:    mp_start = 9'd214;
      4'd8:    mp_start = 9'd245;
      4'd9:    mp_start = 9'd275;
      4'd10:   mp_start = 9'd306;
      4'd11:   mp_start = 9'd337;
      default: mp_start = 9'd0;
    endcase
  endfunction

endpackage

// File: sv/utc_to_cet_local_time.sv
// UTC seconds to Central European local time (CET / CEST).
//
// Input item on s_*: s_tdata carries a Unix UTC seconds count. Result item on
// m_*: m_tdata carries the local broken-down time and m_tuser the summer-time
// flag. Every input item produces exactly one result item, in order.
//
// The converter is a 9-stage pipeline: divide by 86400, remainder, six stages
// of date split (done twice in parallel, on the UTC day and the day after)
// beside the hour/minute/second split, and a final stage that decides summer
// time from the UTC date, adds the hour offset and picks the UTC day or the
// next one. With m_tready high one item enters and one leaves every cycle.
//
// Each stage carries a valid bit and loads when it is empty or its successor
// loads, so a stalled receiver holds the output register and the pipeline
// keeps filling its bubbles; s_tready drops only when all 9 stages are full.
// rst (synchronous, active high) empties the pipeline; no item survives it.
`include "assert_macros.svh"

module utc_to_cet_local_time (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] utc_seconds
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [11:0] year, [15:12] month, [20:16] day,
                                 // [25:21] hour, [31:26] minute, [37:32] second,
                                 // [40:38] weekday, [49:41] day_of_year, [55:50] zero
  output logic        m_tuser    // [0] dst_active
);

  localparam int NS = uctc_pkg::PIPE_STAGES;
  localparam int SS = uctc_pkg::SPLIT_STAGES;

  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  // Load enables: a stage advances when empty or when the next one advances.
  always_comb begin
    en[NS-1] = !vld[NS-1] || m_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign s_tready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Stage 0: UTC day count via reciprocal multiply of utc / 128 by 1 / 675
  logic [50:0] day_prod;
  logic [31:0] utc0;
  logic [uctc_pkg::DAYS_W-1:0] udays0;

  assign day_prod = s_tdata[31:7] * uctc_pkg::DAY_MUL;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      utc0   <= s_tdata;
      udays0 <= day_prod[uctc_pkg::DAY_K+uctc_pkg::DAYS_W-1:uctc_pkg::DAY_K];
    end
  end

  // Stage 1: UTC second of day
  logic [31:0] day_base;
  logic [31:0] usod_c;
  logic [uctc_pkg::DAYS_W-1:0] udays1;
  logic [uctc_pkg::SOD_W-1:0]  usod1;

  always_comb begin
    day_base = 32'(udays0) * uctc_pkg::SECS_PER_DAY;
    usod_c   = utc0 - day_base;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      udays1 <= udays0;
      usod1  <= usod_c[uctc_pkg::SOD_W-1:0];
    end
  end

  // Stages 2 to 7: split the UTC day and the next day into dates, and the
  // UTC second of day into hour, minute and second.
  uctc_pkg::civil_t civ_utc;
  uctc_pkg::civil_t civ_next;
  uctc_pkg::hms_t   hms_utc;
  logic [uctc_pkg::DAYS_W-1:0] udays_next;

  assign udays_next = udays1 + uctc_pkg::DAYS_W'(1);

  uctc_civil u_civ_utc (
    .clk  (clk),
    .en   (en[SS+1:2]),
    .days (udays1),
    .civ  (civ_utc)
  );

  uctc_civil u_civ_next (
    .clk  (clk),
    .en   (en[SS+1:2]),
    .days (udays_next),
    .civ  (civ_next)
  );

  uctc_hms u_hms (
    .clk (clk),
    .en  (en[SS+1:2]),
    .sod (usod1),
    .hms (hms_utc)
  );

  // Final stage: summer time on the UTC date and hour, then the local offset.
  // In the changeover months the last Sunday is already reached when the day
  // minus the weekday is at least 25.
  logic             on_or_after;
  logic             is_sunday;
  logic             dst_c;
  logic [4:0]       lhour;
  logic             wrap;
  uctc_pkg::civil_t civ_sel;
  logic [4:0]       hour_c;

  always_comb begin
    on_or_after = {1'b0, civ_utc.day} >= uctc_pkg::LAST_WEEK_START + 6'(civ_utc.weekday);
    is_sunday   = civ_utc.weekday == uctc_pkg::SUNDAY;
    if (civ_utc.month < uctc_pkg::MONTH_MAR || civ_utc.month > uctc_pkg::MONTH_OCT) begin
      dst_c = 1'b0;
    end else if (civ_utc.month == uctc_pkg::MONTH_MAR) begin
      // Summer time starts at 01:00 UTC on the last Sunday.
      dst_c = on_or_after && (!is_sunday || hms_utc.hour != 5'd0);
    end else if (civ_utc.month == uctc_pkg::MONTH_OCT) begin
      // Summer time ends at 01:00 UTC on the last Sunday.
      dst_c = !on_or_after || (is_sunday && hms_utc.hour == 5'd0);
    end else begin
      dst_c = 1'b1;
    end
    lhour   = hms_utc.hour + 5'd1 + 5'(dst_c);
    wrap    = lhour >= uctc_pkg::HOURS_PER_DAY;
    civ_sel = wrap ? civ_next : civ_utc;
    hour_c  = wrap ? lhour - uctc_pkg::HOURS_PER_DAY : lhour;
  end

  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [2:0]  weekday;
  logic [8:0]  day_of_year;
  logic        dst_active;

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      year        <= civ_sel.year;
      month       <= civ_sel.month;
      day         <= civ_sel.day;
      hour        <= hour_c;
      minute      <= hms_utc.minute;
      second      <= hms_utc.second;
      weekday     <= civ_sel.weekday;
      day_of_year <= civ_sel.yday;
      dst_active  <= dst_c;
    end
  end

  assign m_tvalid = vld[NS-1];
  assign m_tdata  = {6'b0, day_of_year, weekday, second, minute, hour, day, month, year};
  assign m_tuser  = dst_active;

  // A valid result always carries an in-range clock time and calendar month.
  `CHK_SAME(a_time_range, clk, rst, m_tvalid, hour < 5'd24 && minute < 6'd60 && second < 6'd60, "local time field out of range")
  `CHK_SAME(a_date_range, clk, rst, m_tvalid, month >= 4'd1 && month <= 4'd12 && day >= 5'd1, "local date field out of range")
  // Summer time never flags outside March to October.
  `CHK_SAME(a_dst_season, clk, rst, m_tvalid && dst_active, month >= uctc_pkg::MONTH_MAR && month <= uctc_pkg::MONTH_OCT, "summer time outside its season")
  // An item moving into the output stage must show up there.
  `CHK_NEXT(a_last_load, clk, rst, vld[NS-2] && en[NS-1], m_tvalid, "item lost at output stage")

endmodule

// File: sv/uctc_civil.sv
module uctc_civil (
  input  logic                                 clk,
  input  logic [uctc_pkg::SPLIT_STAGES-1:0]   en,
  input  logic [uctc_pkg::DAYS_W-1:0]         days,
  output uctc_pkg::civil_t                     civ
);

  // Stage 1: era select, day of era, weekday quotient
  logic [19:0] z_c;
  logic        era5_c;
  logic [17:0] doe_c;
  logic [15:0] wx_c;
  logic [32:0] wprod;
  logic [17:0] doe1;
  logic        era51;
  logic [15:0] wx1;
  logic [12:0] wq1;

  always_comb begin
    z_c    = 20'(days) + uctc_pkg::EPOCH_SHIFT;
    era5_c = z_c >= uctc_pkg::ERA5_START;
    doe_c  = era5_c ? 18'(z_c - uctc_pkg::ERA5_START) : 18'(z_c - uctc_pkg::ERA4_START);
    wx_c   = days + 16'd4;
    wprod  = wx_c * uctc_pkg::WD_MUL;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      doe1  <= doe_c;
      era51 <= era5_c;
      wx1   <= wx_c;
      wq1   <= wprod[uctc_pkg::WD_K+12:uctc_pkg::WD_K];
    end
  end

  // Stage 2: leap-corrected day of era, weekday remainder
  logic [36:0] cprod;
  logic [6:0]  q1460;
  logic [2:0]  q36524;
  logic        last_day;
  logic [17:0] t_c;
  logic [15:0] wr_c;
  logic [17:0] t2;
  logic [17:0] doe2;
  logic        era52;
  logic [2:0]  wd2;

  always_comb begin
    cprod    = doe1 * uctc_pkg::C4Y_MUL;
    q1460    = cprod[uctc_pkg::C4Y_K+6:uctc_pkg::C4Y_K];
    q36524   = 3'(doe1 >= 18'd36524) + 3'(doe1 >= 18'd73048) +
               3'(doe1 >= 18'd109572) + 3'(doe1 >= 18'd146096);
    last_day = doe1 == 18'd146096;
    t_c      = doe1 - 18'(q1460) + 18'(q36524) - 18'(last_day);
    wr_c     = wx1 - ((16'(wq1) << 3) - 16'(wq1));
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      t2    <= t_c;
      doe2  <= doe1;
      era52 <= era51;
      wd2   <= wr_c[2:0];
    end
  end

  // Stage 3: year of era
  logic [36:0] yprod;
  logic [8:0]  yoe3;
  logic [17:0] doe3;
  logic        era53;
  logic [2:0]  wd3;

  assign yprod = t2 * uctc_pkg::YR_MUL;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      yoe3  <= yprod[uctc_pkg::YR_K+8:uctc_pkg::YR_K];
      doe3  <= doe2;
      era53 <= era52;
      wd3   <= wd2;
    end
  end

  // Stage 4: March-based day of year
  logic [1:0]  c100;
  logic [17:0] ystart;
  logic [8:0]  doy_c;
  logic [8:0]  doy4;
  logic [8:0]  yoe4;
  logic        era54;
  logic [2:0]  wd4;

  always_comb begin
    c100   = 2'(yoe3 >= 9'd100) + 2'(yoe3 >= 9'd200) + 2'(yoe3 >= 9'd300);
    ystart = 18'(yoe3) * 18'd365 + 18'(yoe3 >> 2) - 18'(c100);
    doy_c  = 9'(doe3 - ystart);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      doy4  <= doy_c;
      yoe4  <= yoe3;
      era54 <= era53;
      wd4   <= wd3;
    end
  end

  // Stage 5: March-based month
  logic [10:0] mx;
  logic [22:0] mprod;
  logic [3:0]  mp5;
  logic [8:0]  doy5;
  logic [8:0]  yoe5;
  logic        era55;
  logic [2:0]  wd5;

  always_comb begin
    mx    = (11'(doy4) << 2) + 11'(doy4) + 11'd2;
    mprod = mx * uctc_pkg::MP_MUL;
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      mp5   <= mprod[uctc_pkg::MP_K+3:uctc_pkg::MP_K];
      doy5  <= doy4;
      yoe5  <= yoe4;
      era55 <= era54;
      wd5   <= wd4;
    end
  end

  // Stage 6: calendar fields
  logic        jan_feb;
  logic        leap;
  logic [11:0] year_c;
  logic [8:0]  dom_c;
  uctc_pkg::civil_t civ_c;

  always_comb begin
    jan_feb       = mp5 >= 4'd10;
    year_c        = 12'(yoe5) + (era55 ? uctc_pkg::ERA5_YEAR : uctc_pkg::ERA4_YEAR) +
                    12'(jan_feb);
    leap          = (year_c[1:0] == 2'b00) && (year_c != uctc_pkg::NONLEAP_CENT);
    dom_c         = doy5 - uctc_pkg::mp_start(mp5) + 9'd1;
    civ_c.year    = year_c;
    civ_c.month   = jan_feb ? mp5 - 4'd9 : mp5 + 4'd3;
    civ_c.day     = dom_c[4:0];
    civ_c.weekday = wd5;
    civ_c.yday    = jan_feb ? doy5 - 9'd306 : doy5 + 9'd59 + 9'(leap);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      civ <= civ_c;
    end
  end

endmodule

// File: sv/uctc_hms.sv
module uctc_hms (
  input  logic                               clk,
  input  logic [uctc_pkg::SPLIT_STAGES-1:0] en,
  input  logic [uctc_pkg::SOD_W-1:0]        sod,
  output uctc_pkg::hms_t                     hms
);

  // Stage 1: hour
  logic [34:0] hprod;
  logic [4:0]  hour1;
  logic [16:0] sod1;

  assign hprod = sod * uctc_pkg::HR_MUL;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      hour1 <= hprod[uctc_pkg::HR_K+4:uctc_pkg::HR_K];
      sod1  <= sod;
    end
  end

  // Stage 2: seconds within the hour
  logic [16:0] hbase;
  logic [16:0] rem_c;
  logic [4:0]  hour2;
  logic [11:0] rem2;

  always_comb begin
    hbase = 17'(hour1) * 17'(uctc_pkg::SECS_PER_HOUR);
    rem_c = sod1 - hbase;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      hour2 <= hour1;
      rem2  <= rem_c[11:0];
    end
  end

  // Stage 3: minute
  logic [24:0] mprod;
  logic [4:0]  hour3;
  logic [11:0] rem3;
  logic [5:0]  min3;

  assign mprod = rem2 * uctc_pkg::MN_MUL;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      hour3 <= hour2;
      rem3  <= rem2;
      min3  <= mprod[uctc_pkg::MN_K+5:uctc_pkg::MN_K];
    end
  end

  // Stage 4: second
  logic [11:0] sec_c;
  uctc_pkg::hms_t hms4;
  uctc_pkg::hms_t hms5;

  assign sec_c = rem3 - ((12'(min3) << 6) - (12'(min3) << 2));

  always_ff @(posedge clk) begin
    if (en[3]) begin
      hms4.hour   <= hour3;
      hms4.minute <= min3;
      hms4.second <= sec_c[5:0];
    end
  end

  // Stages 5 and 6: hold alignment with the date splitter
  always_ff @(posedge clk) begin
    if (en[4]) begin
      hms5 <= hms4;
    end
    if (en[5]) begin
      hms <= hms5;
    end
  end

endmodule
